>>> rtl/pal_pkg.sv
`timescale 1ns / 1ps
package pal_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    CMD_GET       = 4'd0,
    CMD_SET       = 4'd1,
    CMD_SEARCH    = 4'd2,
    CMD_INS_FIRST = 4'd3,
    CMD_INS_AT    = 4'd4,
    CMD_INS_LAST  = 4'd5,
    CMD_DEL_FIRST = 4'd6,
    CMD_DEL_AT    = 4'd7,
    CMD_DEL_LAST  = 4'd8,
    CMD_CLEAR     = 4'd9
  } pal_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } pal_status_t;

  typedef enum logic [2:0] {
    OPC_NONE,
    OPC_GET,
    OPC_SET,
    OPC_SEARCH,
    OPC_INSERT,
    OPC_DELETE
  } pal_opc_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_GET_CAP,
    S_SEARCH,
    S_SHIFT,
    S_DRAIN,
    S_WRITE,
    S_RESP
  } pal_state_t;

  typedef struct packed {
    logic [3:0]         command;
    logic [5:0]         position;
    logic signed [31:0] value;
  } pal_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic [6:0]         length;
    logic [1:0]         status;
  } pal_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_ptr;
    logic rd_pos;
    logic shift;
    logic search;
    logic step;
    logic cap;
    logic wr_val;
  } pal_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    pal_opc_t opc;
    logic     ok;
    logic     work;
    logic     at_end;
  } pal_sts_t;

endpackage

>>> rtl/pal_ctrl.sv
`timescale 1ns / 1ps
module pal_ctrl import pal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_strobe,
  input  pal_sts_t sts,
  output pal_ctl_t ctl
);

  pal_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (!sts.ok) begin
          state_nxt = S_RESP;
        end else begin
          case (sts.opc)
            OPC_GET:    state_nxt = S_GET_CAP;
            OPC_SET:    state_nxt = S_WRITE;
            OPC_SEARCH: state_nxt = sts.work ? S_SEARCH : S_RESP;
            OPC_INSERT: state_nxt = sts.work ? S_SHIFT : S_WRITE;
            OPC_DELETE: state_nxt = sts.work ? S_SHIFT : S_RESP;
            default:    state_nxt = S_RESP;
          endcase
        end
      end
      S_GET_CAP: state_nxt = S_RESP;
      S_SEARCH: begin
        if (sts.at_end) state_nxt = S_DRAIN;
      end
      S_SHIFT: begin
        if (sts.at_end) state_nxt = S_DRAIN;
      end
      // Lets the last pending shift write or search compare complete.
      S_DRAIN: state_nxt = (sts.opc == OPC_INSERT) ? S_WRITE : S_RESP;
      S_WRITE: state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    busy       = (state_r != S_IDLE);
    out_strobe = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctl.load = start;
      end
      S_DECODE: begin
        ctl.rd_pos = sts.ok && (sts.opc == OPC_GET);
      end
      S_GET_CAP: begin
        ctl.cap = 1'b1;
      end
      S_SEARCH: begin
        ctl.rd_ptr = 1'b1;
        ctl.search = 1'b1;
        ctl.step   = !sts.at_end;
      end
      S_SHIFT: begin
        ctl.rd_ptr = 1'b1;
        ctl.shift  = 1'b1;
        ctl.step   = !sts.at_end;
      end
      S_WRITE: begin
        ctl.wr_val = 1'b1;
      end
      S_RESP: begin
        out_strobe = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

>>> rtl/pal_dp.sv
`timescale 1ns / 1ps
module pal_dp import pal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  pal_in_t  in_item,
  input  pal_ctl_t ctl,
  output pal_sts_t sts,
  output pal_out_t out_item
);

  logic [DATA_WIDTH-1:0] mem [MAX_ENTRIES];

  logic [CNT_W-1:0]      cnt_r;
  pal_opc_t              opc_r;
  logic                  ok_r;
  logic                  work_r;
  logic [IDX_W-1:0]      eff_r;
  logic [IDX_W-1:0]      ptr_r;
  logic [IDX_W-1:0]      end_r;
  logic [DATA_WIDTH-1:0] val_r;
  pal_status_t           status_r;
  logic                  found_r;
  logic [DATA_WIDTH-1:0] rval_r;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  pend_r;
  logic [IDX_W-1:0]      pend_addr_r;
  logic                  srch_pend_r;

  pal_opc_t         opc_c;
  pal_status_t      status_c;
  logic             work_c;
  logic [CNT_W-1:0] pos_c;
  logic [CNT_W-1:0] eff_c;
  logic [CNT_W-1:0] start_c;
  logic [CNT_W-1:0] end_c;
  logic [CNT_W-1:0] cnt_c;

  // Precondition checks and loop bounds, worked out as the item is taken.
  always_comb begin
    pos_c    = CNT_W'(in_item.position);
    opc_c    = OPC_NONE;
    status_c = ST_OK;
    work_c   = 1'b0;
    eff_c    = pos_c;
    start_c  = '0;
    end_c    = '0;
    cnt_c    = cnt_r;
    case (in_item.command)
      CMD_GET, CMD_SET: begin
        opc_c = (in_item.command == CMD_GET) ? OPC_GET : OPC_SET;
        if (cnt_r == '0) begin
          status_c = ST_EMPTY;
        end else if (pos_c >= cnt_r) begin
          status_c = ST_RANGE;
        end
      end
      CMD_SEARCH: begin
        opc_c   = OPC_SEARCH;
        work_c  = (cnt_r != '0);
        start_c = '0;
        end_c   = cnt_r - CNT_W'(1);
      end
      CMD_INS_FIRST, CMD_INS_AT, CMD_INS_LAST: begin
        opc_c = OPC_INSERT;
        if (in_item.command == CMD_INS_FIRST) begin
          eff_c = '0;
        end else if (in_item.command == CMD_INS_LAST) begin
          eff_c = cnt_r;
        end
        if (cnt_r >= CNT_W'(MAX_ENTRIES)) begin
          status_c = ST_FULL;
        end else if (in_item.command == CMD_INS_AT && pos_c > cnt_r) begin
          status_c = ST_RANGE;
        end else begin
          cnt_c = cnt_r + CNT_W'(1);
        end
        work_c  = (eff_c != cnt_r);
        start_c = cnt_r - CNT_W'(1);
        end_c   = eff_c;
      end
      CMD_DEL_FIRST, CMD_DEL_AT, CMD_DEL_LAST: begin
        opc_c = OPC_DELETE;
        if (in_item.command == CMD_DEL_FIRST) begin
          eff_c = '0;
        end else if (in_item.command == CMD_DEL_LAST) begin
          eff_c = cnt_r - CNT_W'(1);
        end
        if (cnt_r == '0) begin
          status_c = ST_EMPTY;
        end else if (in_item.command == CMD_DEL_AT && pos_c >= cnt_r) begin
          status_c = ST_RANGE;
        end else begin
          cnt_c = cnt_r - CNT_W'(1);
        end
        work_c  = ((eff_c + CNT_W'(1)) < cnt_r);
        start_c = eff_c + CNT_W'(1);
        end_c   = cnt_r - CNT_W'(1);
      end
      CMD_CLEAR: begin
        cnt_c = '0;
      end
      default: begin
        opc_c = OPC_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      srch_pend_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      pend_r      <= ctl.rd_ptr && ctl.shift;
      srch_pend_r <= ctl.rd_ptr && ctl.search;
      if (ctl.load) begin
        cnt_r   <= cnt_c;
        found_r <= 1'b0;
      end else if (srch_pend_r && (rdata_r == val_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      opc_r    <= opc_c;
      ok_r     <= (status_c == ST_OK);
      status_r <= status_c;
      work_r   <= work_c;
      eff_r    <= eff_c[IDX_W-1:0];
      ptr_r    <= start_c[IDX_W-1:0];
      end_r    <= end_c[IDX_W-1:0];
      val_r    <= in_item.value[DATA_WIDTH-1:0];
      rval_r   <= '0;
    end else begin
      if (ctl.step) begin
        ptr_r <= (opc_r == OPC_INSERT) ? ptr_r - IDX_W'(1) : ptr_r + IDX_W'(1);
      end
      if (ctl.cap) begin
        rval_r <= rdata_r;
      end
    end
    if (ctl.rd_ptr) begin
      pend_addr_r <= (opc_r == OPC_INSERT) ? ptr_r + IDX_W'(1) : ptr_r - IDX_W'(1);
    end
  end

  // An entry read during a shift is written one slot over in the next cycle.
  always_ff @(posedge clk) begin
    if (pend_r) begin
      mem[pend_addr_r] <= rdata_r;
    end else if (ctl.wr_val) begin
      mem[eff_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_ptr) begin
      rdata_r <= mem[ptr_r];
    end else if (ctl.rd_pos) begin
      rdata_r <= mem[eff_r];
    end
  end

  always_comb begin
    sts.opc    = opc_r;
    sts.ok     = ok_r;
    sts.work   = work_r;
    sts.at_end = (ptr_r == end_r);
  end

  always_comb begin
    out_item.read_value = rval_r;
    out_item.found      = found_r;
    out_item.length     = cnt_r;
    out_item.status     = status_r;
  end

endmodule

>>> rtl/positional_array_list.sv
`timescale 1ns / 1ps
// Clear, refused and unknown items and a delete that needs no shift go from S_DECODE straight
// to S_RESP; get, set and an insert that needs no shift pass S_GET_CAP or S_WRITE first. Search,
// shifting insert and shifting delete walk one entry per cycle, a search at most MAX_ENTRIES.
// One item is in work at a time; busy stays high through the result cycle, and a new item can
// start in the cycle after out_strobe. out_strobe marks one cycle and cannot be held.
// Synchronous active-low reset empties the list at once; entry contents stay unknown.
module positional_array_list import pal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pal_in_t  in_item,
  output logic     out_strobe,
  output pal_out_t out_item
);

  pal_ctl_t ctl;
  pal_sts_t sts;

  pal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .sts        (sts),
    .ctl        (ctl)
  );

  pal_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .ctl      (ctl),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pal_pkg::*;

  localparam int RANDOM_ITEMS  = 1820;
  localparam int QUIET_TAIL    = 150;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int REPORT_LIMIT  = 10;
  localparam int CMD_UNUSED_LO = 10;
  localparam int CMD_CODE_MAX  = 15;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  // Shadow copy of the list; works out the result of every accepted item.
  class list_tracker;
    logic [DATA_WIDTH-1:0] slots [MAX_ENTRIES];
    int unsigned count;
    pal_out_t    awaited_results [$];
    int unsigned errors;
    int unsigned cmd_seen [16];
    int unsigned status_seen [4];
    int unsigned search_hits;
    int unsigned longest;

    function void note_command(pal_in_t it);
      pal_out_t want;
      int       slot;
      int       j;
      want = '0;
      want.status = ST_OK;
      slot = -1;
      case (it.command)
        CMD_GET, CMD_SET: begin
          if (count == 0) begin
            want.status = ST_EMPTY;
          end else if (it.position >= count) begin
            want.status = ST_RANGE;
          end else if (it.command == CMD_GET) begin
            want.read_value = slots[it.position];
          end else begin
            slots[it.position] = it.value;
          end
        end
        CMD_SEARCH: begin
          for (j = 0; j < int'(count); j++) begin
            if (slots[j] == it.value) want.found = 1'b1;
          end
        end
        CMD_INS_FIRST, CMD_INS_AT, CMD_INS_LAST: begin
          // A full list wins over a bad position.
          if (count >= MAX_ENTRIES) begin
            want.status = ST_FULL;
          end else if (it.command == CMD_INS_FIRST) begin
            slot = 0;
          end else if (it.command == CMD_INS_LAST) begin
            slot = int'(count);
          end else if (it.position > count) begin
            want.status = ST_RANGE;
          end else begin
            slot = int'(it.position);
          end
          if (slot >= 0) begin
            for (j = int'(count); j > slot; j--) slots[j] = slots[j - 1];
            slots[slot] = it.value;
            count++;
          end
        end
        CMD_DEL_FIRST, CMD_DEL_AT, CMD_DEL_LAST: begin
          if (count == 0) begin
            want.status = ST_EMPTY;
          end else if (it.command == CMD_DEL_FIRST) begin
            slot = 0;
          end else if (it.command == CMD_DEL_LAST) begin
            slot = int'(count) - 1;
          end else if (it.position >= count) begin
            want.status = ST_RANGE;
          end else begin
            slot = int'(it.position);
          end
          if (slot >= 0) begin
            for (j = slot; j + 1 < int'(count); j++) slots[j] = slots[j + 1];
            count--;
          end
        end
        CMD_CLEAR: count = 0;
        default: ;
      endcase
      want.length = 7'(count);
      awaited_results.push_back(want);
      cmd_seen[it.command]++;
      status_seen[want.status]++;
      if (want.found) search_hits++;
      if (count > longest) longest = count;
    endfunction

    function void check_result(pal_out_t got);
      pal_out_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Unexpected result: read_value=%h found=%b length=%0d status=%0d",
                   got.read_value, got.found, got.length, got.status);
        return;
      end
      want = awaited_results.pop_front();
      if (got.read_value !== want.read_value || got.found !== want.found ||
          got.length !== want.length || got.status !== want.status) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("Mismatch at %0t: expected read_value=%h found=%b length=%0d status=%0d",
                   $realtime, want.read_value, want.found, want.length, want.status);
          $display("  got read_value=%h found=%b length=%0d status=%0d",
                   got.read_value, got.found, got.length, got.status);
        end
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  pal_in_t  in_item;
  logic     out_strobe;
  pal_out_t out_item;

  list_tracker   tracker;
  int unsigned   cycle_count = 0;
  int unsigned   random_sent;
  int unsigned   phase_len;
  int unsigned   idle_pct;
  int unsigned   k;
  traffic_mode_t mode;
  pal_in_t       item;

  positional_array_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, tracker.awaited_results.size());
      $display("FAILED: results differ");
      $finish;
    end else if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      tracker.check_result(out_item);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item was taken.
  task automatic send_item(pal_in_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    tracker.note_command(it);
    @(negedge clk);
  endtask

  task automatic send_cmd(logic [3:0] cmd, int unsigned pos, logic [31:0] val);
    pal_in_t it;
    it.command  = cmd;
    it.position = IDX_W'(pos);
    it.value    = val;
    send_item(it);
  endtask

  task automatic idle_for(int unsigned n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    @(negedge clk);
    while (tracker.awaited_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [3:0] choose_command(traffic_mode_t m);
    int unsigned r;
    int unsigned ins_w;
    int unsigned del_w;
    ins_w = (m == MODE_FILL) ? 70 : (m == MODE_DRAIN) ? 10 : 35;
    del_w = (m == MODE_DRAIN) ? 70 : (m == MODE_FILL) ? 10 : 30;
    r = $urandom_range(0, 99);
    if (r < ins_w) begin
      case ($urandom_range(0, 2))
        0:       return CMD_INS_FIRST;
        1:       return CMD_INS_AT;
        default: return CMD_INS_LAST;
      endcase
    end
    if (r < ins_w + del_w) begin
      case ($urandom_range(0, 2))
        0:       return CMD_DEL_FIRST;
        1:       return CMD_DEL_AT;
        default: return CMD_DEL_LAST;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 3)  return 4'($urandom_range(CMD_UNUSED_LO, CMD_CODE_MAX));
    if (r < 6)  return CMD_CLEAR;
    if (r < 40) return CMD_GET;
    if (r < 65) return CMD_SET;
    return CMD_SEARCH;
  endfunction

  // Corner values often, so that searches hit and the sign bit flips.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '1;
      3:       return '0;
      4, 5:    return 32'($urandom_range(1, 8));
      default: return $urandom;
    endcase
  endfunction

  function automatic pal_in_t make_item(traffic_mode_t m);
    pal_in_t     it;
    int unsigned n;
    int unsigned sel;
    n = tracker.count;
    it.command = choose_command(m);
    sel = $urandom_range(0, 99);
    if (sel < 55)      it.position = IDX_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
    else if (sel < 70) it.position = IDX_W'(n);
    else               it.position = IDX_W'($urandom_range(0, MAX_ENTRIES - 1));
    if (it.command == CMD_SEARCH && n > 0 && $urandom_range(0, 1) == 1)
      it.value = tracker.slots[$urandom_range(0, n - 1)];
    else
      it.value = pick_value();
    return it;
  endfunction

  initial begin
    tracker = new;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // On an empty list get, set and delete are refused; search is not, and an insert only at a bad position.
    send_cmd(CMD_GET, 0, 32'h0);
    send_cmd(CMD_SET, 0, 32'h1111_1111);
    send_cmd(CMD_SEARCH, 0, 32'h0);
    send_cmd(CMD_DEL_FIRST, 0, 32'h0);
    send_cmd(CMD_DEL_AT, 0, 32'h0);
    send_cmd(CMD_DEL_LAST, 0, 32'h0);
    send_cmd(CMD_INS_AT, 1, 32'h2222_2222);
    send_cmd(CMD_INS_AT, 0, 32'h7FFF_FFFF);
    send_cmd(CMD_INS_FIRST, 0, 32'h8000_0000);
    send_cmd(CMD_INS_LAST, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_INS_AT, 1, 32'h0);
    // Inserting at the current length appends.
    send_cmd(CMD_INS_AT, 4, 32'h5A5A_5A5A);
    send_cmd(CMD_INS_AT, MAX_ENTRIES - 1, 32'h3333_3333);
    send_cmd(CMD_GET, 0, 32'h0);
    send_cmd(CMD_GET, 4, 32'h0);
    send_cmd(CMD_GET, 5, 32'h0);
    send_cmd(CMD_GET, MAX_ENTRIES - 1, 32'h0);
    send_cmd(CMD_SET, 2, 32'h1234_5678);
    send_cmd(CMD_SET, 5, 32'h0);
    send_cmd(CMD_SEARCH, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_SEARCH, 0, 32'h7FFF_FFFF);
    send_cmd(CMD_DEL_AT, 7, 32'h0);
    send_cmd(CMD_DEL_AT, 1, 32'h0);
    send_cmd(CMD_DEL_FIRST, 0, 32'h0);
    send_cmd(CMD_DEL_LAST, 0, 32'h0);
    send_cmd(4'(CMD_CODE_MAX), 0, 32'hFFFF_FFFF);
    send_cmd(CMD_CLEAR, 0, 32'h0);
    send_cmd(CMD_GET, 0, 32'h0);
    wait_all_results();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (tracker.count < 16 && $urandom_range(0, 1) == 1)
        mode = MODE_FILL;
      else if (tracker.count > 48 && $urandom_range(0, 1) == 1)
        mode = MODE_DRAIN;
      else
        mode = traffic_mode_t'($urandom_range(0, 2));
      phase_len = (mode == MODE_MIX) ? $urandom_range(40, 120) : $urandom_range(100, 200);
      idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : 30;
      for (k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
        item = make_item(mode);
        send_item(item);
        if (item.command <= CMD_CLEAR) random_sent++;
        if (RANDOM_ITEMS - random_sent > QUIET_TAIL && idle_pct > 0 &&
            $urandom_range(0, 99) < idle_pct)
          idle_for($urandom_range(1, 6));
      end
      if (RANDOM_ITEMS - random_sent > QUIET_TAIL && $urandom_range(0, 1) == 1)
        wait_all_results();
    end

    start <= 1'b0;
    @(negedge clk);
    while (tracker.awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (tracker.awaited_results.size() != 0) begin
      tracker.errors++;
      $display("%0d expected results never arrived.", tracker.awaited_results.size());
    end
    $display("Issued %0d gets, %0d sets, %0d searches (%0d hits), %0d inserts, %0d deletes.",
             tracker.cmd_seen[CMD_GET], tracker.cmd_seen[CMD_SET],
             tracker.cmd_seen[CMD_SEARCH], tracker.search_hits,
             tracker.cmd_seen[CMD_INS_FIRST] + tracker.cmd_seen[CMD_INS_AT] +
             tracker.cmd_seen[CMD_INS_LAST],
             tracker.cmd_seen[CMD_DEL_FIRST] + tracker.cmd_seen[CMD_DEL_AT] +
             tracker.cmd_seen[CMD_DEL_LAST]);
    $display("Longest list %0d entries; refusals: %0d full, %0d empty, %0d bad position.",
             tracker.longest, tracker.status_seen[ST_FULL], tracker.status_seen[ST_EMPTY],
             tracker.status_seen[ST_RANGE]);
    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total.", tracker.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pal_pkg.sv
rtl/pal_ctrl.sv
rtl/pal_dp.sv
rtl/positional_array_list.sv
tb/sv/testbench.sv
